FILE: hdl/fop_pkg.sv
// Shared constants and a helper function of the perpendicular-foot block.
package fop_pkg;

    // Default coordinate width (signed Q24.8 at 32 bits).
    localparam int CW_DEFAULT = 32;

    // Width of the multiplier operand slice handled in one pipeline stage.
    localparam int MUL_SLICE = 16;

    function automatic int fop_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: hdl/fop_if.sv
// Valid/ready channel interfaces for the query items and the result items.
interface fop_in_if import fop_pkg::*; #(
    parameter int W = CW_DEFAULT
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] line_start_x;
    logic signed [W-1:0] line_start_y;
    logic signed [W-1:0] line_end_x;
    logic signed [W-1:0] line_end_y;
    logic signed [W-1:0] query_x;
    logic signed [W-1:0] query_y;

    modport source (
        output valid, line_start_x, line_start_y, line_end_x, line_end_y, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, line_start_x, line_start_y, line_end_x, line_end_y, query_x, query_y,
        output ready
    );
endinterface

interface fop_out_if import fop_pkg::*; #(
    parameter int W = CW_DEFAULT
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] foot_x;
    logic signed [W-1:0] foot_y;
    logic                was_saturated;

    modport source (output valid, foot_x, foot_y, was_saturated, input ready);
    modport sink (input valid, foot_x, foot_y, was_saturated, output ready);
endinterface

FILE: hdl/fop_dly.sv
// Enabled delay line that carries side data and valid bits beside the arithmetic units.
module fop_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_tap[k] <= '0;
            end
        end else if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[N-1];
endmodule

FILE: hdl/fop_mul.sv
// Pipelined signed multiplier that consumes one slice of the second operand per stage.
module fop_mul #(
    parameter int WA = 33,
    parameter int WB = 33,
    parameter int SW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [WA-1:0]  i_a,
    input  logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int NS   = (WB + SW - 1) / SW;
    localparam int WBX  = NS * SW;
    localparam int WACC = WA + WBX;

    logic signed [WA-1:0]   r_a   [0:NS-1];
    logic        [WBX-1:0]  r_b   [0:NS-1];
    logic signed [WACC-1:0] r_acc [0:NS-1];

    logic [WBX-1:0] w_bx;
    assign w_bx = WBX'(i_b);

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic signed [WA-1:0]   w_a;
        logic        [WBX-1:0]  w_b;
        logic signed [WACC-1:0] w_acc_in;
        logic        [SW-1:0]   w_sl;
        logic signed [SW:0]     w_ss;
        logic signed [WA+SW:0]  w_pp;
        logic signed [WACC-1:0] w_ps;

        if (i == 0) begin : g_first
            assign w_a      = i_a;
            assign w_b      = w_bx;
            assign w_acc_in = '0;
        end else begin : g_next
            assign w_a      = r_a[i-1];
            assign w_b      = r_b[i-1];
            assign w_acc_in = r_acc[i-1];
        end

        assign w_sl = w_b[i*SW +: SW];
        // Only the top slice carries the sign of the operand.
        assign w_ss = (i == NS - 1) ? $signed({w_sl[SW-1], w_sl}) : $signed({1'b0, w_sl});
        assign w_pp = w_a * w_ss;
        assign w_ps = WACC'(w_pp) <<< (i * SW);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[i]   <= w_a;
                r_b[i]   <= w_b;
                r_acc[i] <= w_acc_in + w_ps;
            end
        end
    end

    assign o_p = r_acc[NS-1][WA+WB-1:0];
endmodule

FILE: hdl/fop_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, truncating toward zero.
module fop_div import fop_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_n,
    input  logic signed [DW-1:0] i_d,
    output logic signed [QW:0]   o_q
);
    localparam int WW = fop_max(NW, DW + QW);

    logic [NW-1:0] w_nu, w_nabs;
    logic [DW-1:0] w_du, w_dabs;

    logic [WW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_dv  [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_neg [0:QW];
    logic [QW:0]   r_out;

    assign w_nu   = i_n;
    assign w_du   = i_d;
    assign w_nabs = w_nu[NW-1] ? (~w_nu + NW'(1)) : w_nu;
    assign w_dabs = w_du[DW-1] ? (~w_du + DW'(1)) : w_du;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= WW'(w_nabs);
            r_dv[0]  <= w_dabs;
            r_q[0]   <= '0;
            r_neg[0] <= w_nu[NW-1] ^ w_du[DW-1];
        end
    end

    // The quotient magnitude stays below 2**QW, so the search starts at bit QW-1.
    for (genvar j = 1; j <= QW; j++) begin : g_bit
        localparam int B = QW - j;
        logic [WW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = WW'(r_dv[j-1]) << B;
        assign w_ge = (r_rem[j-1] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]    <= w_ge ? (r_rem[j-1] - w_sh) : r_rem[j-1];
                r_dv[j]     <= r_dv[j-1];
                r_q[j]      <= r_q[j-1] | (QW'(w_ge) << B);
                r_neg[j]    <= r_neg[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_neg[QW] ? (~{1'b0, r_q[QW]} + (QW+1)'(1)) : {1'b0, r_q[QW]};
        end
    end

    assign o_q = $signed(r_out);
endmodule

FILE: hdl/foot_of_perpendicular.sv
// Top level: foot of the perpendicular from a query point onto a line, fully pipelined.
//
//  Channel  Dir  Handshake     Payload
//  i_in     in   valid/ready   line_start_x/y, line_end_x/y, query_x/y (signed Q24.8)
//  o_out    out  valid/ready   foot_x, foot_y (signed, saturated), was_saturated
//
// One query is taken per cycle while the output buffer is not full. The pipeline depth
// is set by the two bit-per-stage dividers and the sliced multipliers (NA, NB stages
// each). Reset clears all valid bits and the two-entry output buffer. The whole
// pipeline holds while that buffer is full, so an output stall neither drops nor
// repeats a result.
module foot_of_perpendicular import fop_pkg::*; #(
    parameter int COORD_WIDTH = CW_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fop_in_if.sink   i_in,
    fop_out_if.source o_out
);
    localparam int C   = COORD_WIDTH;
    localparam int W1  = C + 1;
    localparam int WSQ = 2 * C + 2;
    localparam int WDN = 2 * C + 3;
    localparam int WPR = 3 * C + 3;
    localparam int WNM = 3 * C + 5;
    localparam int WX  = C + 2;
    localparam int WT  = C + 3;
    localparam int WP4 = 2 * C + 4;
    localparam int QW2 = 2 * C + 1;
    localparam int WY  = 2 * C + 3;
    localparam int NA  = (W1 + MUL_SLICE - 1) / MUL_SLICE;
    localparam int NB  = (WT + MUL_SLICE - 1) / MUL_SLICE;
    localparam int LD1 = C + 3;
    localparam int LD2 = QW2 + 2;

    logic w_en;

    // ---------------- stage 1: differences ----------------
    logic                r1_v, r1_vert;
    logic signed [C:0]   r1_dx, r1_dy, r1_ry, r1_x1e, r1_x3e;
    logic signed [C-1:0] r1_y1, r1_x2, r1_y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_vert <= (i_in.line_start_x == i_in.line_end_x);
            r1_dx   <= W1'(i_in.line_end_x) - W1'(i_in.line_start_x);
            r1_dy   <= W1'(i_in.line_end_y) - W1'(i_in.line_start_y);
            r1_ry   <= W1'(i_in.query_y) - W1'(i_in.line_start_y);
            r1_x1e  <= W1'(i_in.line_start_x);
            r1_x3e  <= W1'(i_in.query_x);
            r1_y1   <= i_in.line_start_y;
            r1_x2   <= i_in.line_end_x;
            r1_y3   <= i_in.query_y;
        end
    end

    // ---------------- squares and cross term ----------------
    logic signed [WSQ-1:0] w_dx2, w_dy2, w_dxdy;

    fop_mul #(.WA(W1), .WB(W1), .SW(MUL_SLICE)) u_mul_dxdx (
        .i_clk(i_clk), .i_en(w_en), .i_a(r1_dx), .i_b(r1_dx), .o_p(w_dx2)
    );
    fop_mul #(.WA(W1), .WB(W1), .SW(MUL_SLICE)) u_mul_dydy (
        .i_clk(i_clk), .i_en(w_en), .i_a(r1_dy), .i_b(r1_dy), .o_p(w_dy2)
    );
    fop_mul #(.WA(W1), .WB(W1), .SW(MUL_SLICE)) u_mul_dxdy (
        .i_clk(i_clk), .i_en(w_en), .i_a(r1_dx), .i_b(r1_dy), .o_p(w_dxdy)
    );

    localparam int SD1 = 2 + 5 * W1 + 3 * C;
    logic [SD1-1:0] w_d1;
    logic                d1_v, d1_vert;
    logic signed [C:0]   d1_dx, d1_dy, d1_ry, d1_x1e, d1_x3e;
    logic signed [C-1:0] d1_y1, d1_x2, d1_y3;

    fop_dly #(.W(SD1), .N(NA)) u_dly1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({r1_v, r1_vert, r1_dx, r1_dy, r1_ry, r1_x1e, r1_x3e, r1_y1, r1_x2, r1_y3}),
        .o_q(w_d1)
    );
    assign {d1_v, d1_vert, d1_dx, d1_dy, d1_ry, d1_x1e, d1_x3e, d1_y1, d1_x2, d1_y3} = w_d1;

    // ---------------- numerator terms ----------------
    logic signed [WPR-1:0] w_p1, w_p2, w_p3;
    logic signed [WDN-1:0] w_den;

    fop_mul #(.WA(WSQ), .WB(W1), .SW(MUL_SLICE)) u_mul_t1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_dy2), .i_b(d1_x1e), .o_p(w_p1)
    );
    fop_mul #(.WA(WSQ), .WB(W1), .SW(MUL_SLICE)) u_mul_t2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_dx2), .i_b(d1_x3e), .o_p(w_p2)
    );
    fop_mul #(.WA(WSQ), .WB(W1), .SW(MUL_SLICE)) u_mul_t3 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_dxdy), .i_b(d1_ry), .o_p(w_p3)
    );

    assign w_den = WDN'(w_dx2) + WDN'(w_dy2);

    localparam int SD2 = 2 + WDN + 3 * W1 + 3 * C;
    logic [SD2-1:0] w_d2;
    logic                  d2_v, d2_vert;
    logic signed [WDN-1:0] d2_den;
    logic signed [C:0]     d2_dx, d2_dy, d2_x1e;
    logic signed [C-1:0]   d2_y1, d2_x2, d2_y3;

    fop_dly #(.W(SD2), .N(NA)) u_dly2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({d1_v, d1_vert, w_den, d1_dx, d1_dy, d1_x1e, d1_y1, d1_x2, d1_y3}),
        .o_q(w_d2)
    );
    assign {d2_v, d2_vert, d2_den, d2_dx, d2_dy, d2_x1e, d2_y1, d2_x2, d2_y3} = w_d2;

    // ---------------- stage 3: numerator sum ----------------
    logic                  r3_v, r3_vert;
    logic signed [WNM-1:0] r3_num;
    logic signed [WDN-1:0] r3_den;
    logic signed [C:0]     r3_dx, r3_dy, r3_x1e;
    logic signed [C-1:0]   r3_y1, r3_x2, r3_y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_vert <= d2_vert;
            r3_num  <= WNM'(w_p1) + WNM'(w_p2) + WNM'(w_p3);
            r3_den  <= d2_den;
            r3_dx   <= d2_dx;
            r3_dy   <= d2_dy;
            r3_x1e  <= d2_x1e;
            r3_y1   <= d2_y1;
            r3_x2   <= d2_x2;
            r3_y3   <= d2_y3;
        end
    end

    // ---------------- X quotient ----------------
    logic signed [WX-1:0] w_xq;

    fop_div #(.NW(WNM), .DW(WDN), .QW(C + 1)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_n(r3_num), .i_d(r3_den), .o_q(w_xq)
    );

    localparam int SD3 = 2 + 3 * W1 + 3 * C;
    logic [SD3-1:0] w_d3;
    logic                d3_v, d3_vert;
    logic signed [C:0]   d3_dx, d3_dy, d3_x1e;
    logic signed [C-1:0] d3_y1, d3_x2, d3_y3;

    fop_dly #(.W(SD3), .N(LD1)) u_dly3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({r3_v, r3_vert, r3_dx, r3_dy, r3_x1e, r3_y1, r3_x2, r3_y3}),
        .o_q(w_d3)
    );
    assign {d3_v, d3_vert, d3_dx, d3_dy, d3_x1e, d3_y1, d3_x2, d3_y3} = w_d3;

    // ---------------- stage 4: offset along x ----------------
    logic                 r4_v, r4_vert;
    logic signed [WX-1:0] r4_xq;
    logic signed [WT-1:0] r4_t;
    logic signed [C:0]    r4_dx, r4_dy;
    logic signed [C-1:0]  r4_y1, r4_x2, r4_y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_vert <= d3_vert;
            r4_xq   <= w_xq;
            r4_t    <= WT'(w_xq) - WT'(d3_x1e);
            r4_dx   <= d3_dx;
            r4_dy   <= d3_dy;
            r4_y1   <= d3_y1;
            r4_x2   <= d3_x2;
            r4_y3   <= d3_y3;
        end
    end

    logic signed [WP4-1:0] w_p4;

    fop_mul #(.WA(W1), .WB(WT), .SW(MUL_SLICE)) u_mul_rise (
        .i_clk(i_clk), .i_en(w_en), .i_a(r4_dy), .i_b(r4_t), .o_p(w_p4)
    );

    localparam int SD4 = 2 + WX + W1 + 3 * C;
    logic [SD4-1:0] w_d4;
    logic                 d4_v, d4_vert;
    logic signed [WX-1:0] d4_xq;
    logic signed [C:0]    d4_dx;
    logic signed [C-1:0]  d4_y1, d4_x2, d4_y3;

    fop_dly #(.W(SD4), .N(NB)) u_dly4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({r4_v, r4_vert, r4_xq, r4_dx, r4_y1, r4_x2, r4_y3}),
        .o_q(w_d4)
    );
    assign {d4_v, d4_vert, d4_xq, d4_dx, d4_y1, d4_x2, d4_y3} = w_d4;

    // ---------------- Y quotient ----------------
    logic signed [QW2:0] w_yq;

    fop_div #(.NW(WP4), .DW(W1), .QW(QW2)) u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_n(w_p4), .i_d(d4_dx), .o_q(w_yq)
    );

    localparam int SD5 = 2 + WX + 3 * C;
    logic [SD5-1:0] w_d5;
    logic                 d5_v, d5_vert;
    logic signed [WX-1:0] d5_xq;
    logic signed [C-1:0]  d5_y1, d5_x2, d5_y3;

    fop_dly #(.W(SD5), .N(LD2)) u_dly5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({d4_v, d4_vert, d4_xq, d4_y1, d4_x2, d4_y3}),
        .o_q(w_d5)
    );
    assign {d5_v, d5_vert, d5_xq, d5_y1, d5_x2, d5_y3} = w_d5;

    // ---------------- stage 6: final y ----------------
    logic                 r6_v, r6_vert;
    logic signed [WX-1:0] r6_xq;
    logic signed [WY-1:0] r6_yq;
    logic signed [C-1:0]  r6_x2, r6_y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= d5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_vert <= d5_vert;
            r6_xq   <= d5_xq;
            r6_yq   <= WY'(w_yq) + WY'(d5_y1);
            r6_x2   <= d5_x2;
            r6_y3   <= d5_y3;
        end
    end

    // Saturation: a value fits when all bits above the coordinate's sign bit match it.
    logic               w_xfit, w_yfit, w_push;
    logic [C-1:0]       w_fx, w_fy;
    logic [2*C:0]       w_res;

    assign w_xfit = (r6_xq[WX-1:C-1] == '0) || (r6_xq[WX-1:C-1] == '1);
    assign w_yfit = (r6_yq[WY-1:C-1] == '0) || (r6_yq[WY-1:C-1] == '1);
    assign w_fx   = w_xfit ? r6_xq[C-1:0] : {r6_xq[WX-1], {(C-1){~r6_xq[WX-1]}}};
    assign w_fy   = w_yfit ? r6_yq[C-1:0] : {r6_yq[WY-1], {(C-1){~r6_yq[WY-1]}}};
    assign w_res  = r6_vert ? {r6_x2, r6_y3, 1'b0} : {w_fx, w_fy, ~(w_xfit & w_yfit)};
    assign w_push = w_en && r6_v;

    // ---------------- output buffer ----------------
    logic [2*C:0] r_buf [0:1];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt;
    logic         w_pop;

    assign w_en  = (r_cnt != 2'd2);
    assign w_pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_res;
        end
    end

    assign i_in.ready          = w_en;
    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.foot_x        = r_buf[r_rd][2*C:C+1];
    assign o_out.foot_y        = r_buf[r_rd][C:1];
    assign o_out.was_saturated = r_buf[r_rd][0];

    // ---------------- checks ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cnt == 2'd2 && w_push))
        else $error("push into full output buffer");

    a_cnt_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) == (r_wr != r_rd))
        else $error("output buffer pointers disagree with count");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r6_v) && $stable(r3_v))
        else $error("pipeline moved while stalled");
endmodule

FILE: dv/foot_of_perpendicular_tb.sv
// Self-checking testbench for the perpendicular-foot block with directed and random traffic.
`timescale 1ns / 100ps

module foot_of_perpendicular_tb;
    import fop_pkg::*;

    localparam int CW = 32;
    localparam int LATENCY = 3 * CW + 11 + 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
    } query_t;

    typedef struct packed {
        logic signed [CW-1:0] fx, fy;
        logic                 sat;
    } foot_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fop_in_if  #(.W(CW)) in_ch ();
    fop_out_if #(.W(CW)) out_ch ();

    foot_of_perpendicular #(.COORD_WIDTH(CW)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    query_t pending_q[$];
    foot_t  feet_due[$];
    int     errors = 0;
    int     sent = 0;
    int     checked = 0;
    int     saturated_seen = 0;
    int     vertical_sent = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_cycles = 0;
    longint cycles = 0;

    // Clamp a wide value to the coordinate range, flagging saturation.
    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [255:0] v,
                                                          inout logic sat);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< (CW - 1)) - 1;
        lo = -(256'sd1 <<< (CW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    // SystemVerilog signed division truncates toward zero, as the block does.
    function automatic foot_t project_foot(input query_t q);
        foot_t r;
        logic signed [255:0] x1, y1, x2, y2, x3, y3, dx, dy, num, den, xq, yq;
        logic sat;
        sat = 1'b0;
        if (q.x1 == q.x2) begin
            r.fx = q.x2;
            r.fy = q.y3;
            r.sat = 1'b0;
            return r;
        end
        x1 = q.x1; y1 = q.y1; x2 = q.x2; y2 = q.y2; x3 = q.x3; y3 = q.y3;
        dx = x2 - x1;
        dy = y2 - y1;
        num = x1 * dy * dy + x3 * dx * dx + dx * dy * (y3 - y1);
        den = dx * dx + dy * dy;
        xq = num / den;
        yq = (dy * (xq - x1)) / dx + y1;
        r.fx = clamp_coord(xq, sat);
        r.fy = clamp_coord(yq, sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input foot_t got, input foot_t want);
        errors++;
        $display("mismatch %s: got (%0d, %0d, sat %0b) want (%0d, %0d, sat %0b)", what,
                 got.fx, got.fy, got.sat, want.fx, want.fy, want.sat);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 8191)) - 4096;
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        q.x1 = rand_coord(); q.y1 = rand_coord(); q.x2 = rand_coord();
        q.y2 = rand_coord(); q.x3 = rand_coord(); q.y3 = rand_coord();
        case ($urandom_range(0, 9))
            0: q.x2 = q.x1;
            1: q.x2 = q.x1 + ($urandom_range(0, 1) ? 1 : -1);
            2: begin
                q.x2 = q.x1;
                q.y2 = q.y1;
            end
            default: ;
        endcase
        return q;
    endfunction

    function automatic query_t make_query(input logic [CW-1:0] a, b, c, d, e, f);
        query_t q;
        q.x1 = a; q.y1 = b; q.x2 = c; q.y2 = d; q.x3 = e; q.y3 = f;
        return q;
    endfunction

    // Driver: holds an item until it transfers, idles at the chosen rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                feet_due.push_back(project_foot({in_ch.line_start_x, in_ch.line_start_y,
                    in_ch.line_end_x, in_ch.line_end_y, in_ch.query_x, in_ch.query_y}));
                sent++;
                if (in_ch.line_start_x == in_ch.line_end_x) vertical_sent++;
            end
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                query_t q;
                q = pending_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.line_start_x <= q.x1;
                in_ch.line_start_y <= q.y1;
                in_ch.line_end_x <= q.x2;
                in_ch.line_end_y <= q.y2;
                in_ch.query_x <= q.x3;
                in_ch.query_y <= q.y3;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall generation.
    always @(posedge i_clk) begin
        cycles++;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                foot_t got;
                foot_t want;
                got = {out_ch.foot_x, out_ch.foot_y, out_ch.was_saturated};
                if (feet_due.size() == 0) begin
                    errors++;
                    $display("unexpected result (%0d, %0d)", got.fx, got.fy);
                end else begin
                    want = feet_due.pop_front();
                    if (got.fx !== want.fx) report_mismatch("foot_x", got, want);
                    if (got.fy !== want.fy) report_mismatch("foot_y", got, want);
                    if (got.sat !== want.sat) report_mismatch("was_saturated", got, want);
                    if (want.sat) saturated_seen++;
                    checked++;
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[foot_of_perpendicular] ERROR");
            $finish;
        end
    end

    // Checked between edges so the driver and monitor updates have settled.
    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || feet_due.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) pending_q.push_back(rand_query());
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.line_start_x = '0; in_ch.line_start_y = '0;
        in_ch.line_end_x = '0; in_ch.line_end_y = '0;
        in_ch.query_x = '0; in_ch.query_y = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: vertical and degenerate lines, extremes, saturating cases.
        pending_q.push_back(make_query(0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_query(256, -100, 256, 900, 7, 33));
        pending_q.push_back(make_query(5, 5, 5, 5, -9, 12));
        pending_q.push_back(make_query(32'h8000_0000, 0, 32'h8000_0000, 1, 3, 32'h7FFF_FFFF));
        pending_q.push_back(make_query(0, 0, 256, 0, 1000, 5000));
        pending_q.push_back(make_query(0, 0, 256, 256, 512, 0));
        pending_q.push_back(make_query(0, 0, 256, -256, -300, 77));
        pending_q.push_back(make_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_q.push_back(make_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 0, 0));
        pending_q.push_back(make_query(0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        pending_q.push_back(make_query(0, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h8000_0000));
        pending_q.push_back(make_query(-1, 0, 1, 0, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_q.push_back(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                       32'h5555_5555, 32'hFFFF_FFFF, 32'hAAAA_AAAA));
        pending_q.push_back(make_query(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554,
                                       32'h0000_0001, 32'h5555_5555, 32'hFFFF_FFFF));
        drain();

        random_phase(300, 0, 0);
        random_phase(300, 47, 0);
        random_phase(300, 0, 47);
        random_phase(250, 12, 12);

        // Long receiver hold-off with more items than the pipeline holds, so the
        // input backpressures.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 3 * LATENCY;
        repeat (300) pending_q.push_back(rand_query());
        drain();

        repeat (LATENCY) @(posedge i_clk);
        $display("%0d queries sent, %0d results checked (%0d vertical, %0d saturated)",
                 sent, checked, vertical_sent, saturated_seen);
        $display("phases: back to back, idle sender, stalling receiver, both, long stall");
        if (errors == 0 && feet_due.size() == 0) begin
            $display("[foot_of_perpendicular] OK");
        end else begin
            $display("[foot_of_perpendicular] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/fop_pkg.sv
hdl/fop_if.sv
hdl/fop_dly.sv
hdl/fop_mul.sv
hdl/fop_div.sv
hdl/foot_of_perpendicular.sv
dv/foot_of_perpendicular_tb.sv
